### src/pdq_pkg.sv
// ----------------------------------------------------------------------------
// Per-destination packet queue package
// Shared sizes, codes and types of the queue manager.
// ----------------------------------------------------------------------------
`default_nettype none
package pdq_pkg;

  localparam int DEST_SLOTS  = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int ENTRIES     = DEST_SLOTS * QUEUE_DEPTH;
  localparam int SLOT_W      = $clog2(DEST_SLOTS);
  localparam int POS_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = SLOT_W + POS_W;
  localparam int DESC_W      = 96;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NO_ROOM = 2'd2,
    STAT_NO_SLOT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVAL,
    ST_EVICT,
    ST_GET,
    ST_DONE
  } state_t;

  // Result of the destination tag search.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
  } lookup_t;

endpackage
`default_nettype wire

### src/pdq_ram.sv
// ----------------------------------------------------------------------------
// Descriptor RAM
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pdq_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### src/pdq_lookup.sv
// ----------------------------------------------------------------------------
// Destination lookup
// Matches a destination against the slot tags and finds the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none
module pdq_lookup
  import pdq_pkg::*;
(
  input  wire logic [31:0]           dest,
  input  wire logic [31:0]           tags [DEST_SLOTS],
  input  wire logic [DEST_SLOTS-1:0] used,
  output lookup_t                    res
);

  // Lowest matching slot and lowest free slot.
  always_comb begin
    res = '0;
    for (int s = DEST_SLOTS - 1; s >= 0; s--) begin
      if (used[s] && tags[s] == dest) begin
        res.hit     = 1'b1;
        res.hit_idx = SLOT_W'(s);
      end
      if (!used[s]) begin
        res.free_ok  = 1'b1;
        res.free_idx = SLOT_W'(s);
      end
    end
  end

endmodule
`default_nettype wire

### src/per_destination_packet_queue.sv
// ----------------------------------------------------------------------------
// Per-destination packet queue
// Descriptor FIFOs per destination sharing one byte budget, drop oldest.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Every item passes lookup and done; a get
// with a packet adds a get step, a store with a slot an evaluate step, plus an evict
// step and a new evaluate per evicted packet, as every eviction reads the oldest
// descriptor's length from the single-port descriptor RAM. No input is taken while
// an item is in work; a finished result waits until the output register is free.
`default_nettype none
module per_destination_packet_queue
  import pdq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [23:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode, destination, port_id, origin, length, payload_handle, zero pad
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, evicted_count, out_port, out_origin, out_length, out_handle,
  // more_waiting, available_bytes, total_packets, zero pad
  output logic [143:0]      out_tdata
);

  state_t state_r, state_nxt;

  logic [23:0]           cap_r;
  logic [31:0]           tag_r   [DEST_SLOTS];
  logic [DEST_SLOTS-1:0] used_r;
  logic [POS_W-1:0]      head_r  [DEST_SLOTS];
  logic [CNT_W-1:0]      count_r [DEST_SLOTS];
  logic [23:0]           bytes_r;
  logic [9:0]            pkts_r;

  logic [1:0]  mode_r;
  logic [31:0] dest_r, orig_r, handle_r;
  logic [15:0] port_r, len_r;

  logic [SLOT_W-1:0] slot_r;
  logic              slot_ok_r;
  status_t           stat_r;
  logic [4:0]        evict_r;
  logic [DESC_W-1:0] desc_r;

  logic              out_valid_r;
  logic [143:0]      out_data_r;

  lookup_t           lk;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DESC_W-1:0] ram_rdata;
  logic              fits;
  logic              out_free;
  logic [CNT_W-1:0]  cur_cnt;
  logic [POS_W-1:0]  cur_head;
  logic [POS_W-1:0]  tail_pos;
  logic              more;
  logic [23:0]       avail;

  pdq_lookup u_lookup (
    .dest (dest_r),
    .tags (tag_r),
    .used (used_r),
    .res  (lk)
  );

  pdq_ram #(.DEPTH(ENTRIES), .WIDTH(DESC_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({handle_r, orig_r, port_r, len_r}),
    .rdata (ram_rdata)
  );

  assign cur_cnt  = count_r[slot_r];
  assign cur_head = head_r[slot_r];
  assign tail_pos = cur_head + POS_W'(cur_cnt);
  assign fits     = ({1'b0, bytes_r} + 25'(len_r) <= {1'b0, cap_r}) &&
                    (cur_cnt < CNT_W'(QUEUE_DEPTH));
  assign out_free = !out_valid_r || out_tready;
  assign more     = slot_ok_r && (cur_cnt != '0);
  assign avail    = (cap_r > bytes_r) ? cap_r - bytes_r : 24'd0;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (mode_r == MODE_STORE) begin
          state_nxt = (lk.hit || lk.free_ok) ? ST_EVAL : ST_DONE;
        end else if (mode_r == MODE_GET && lk.hit &&
                     count_r[lk.hit_idx] != '0) begin
          state_nxt = ST_GET;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVAL:   state_nxt = (!fits && cur_cnt != '0) ? ST_EVICT : ST_DONE;
      ST_EVICT:  state_nxt = ST_EVAL;
      ST_GET:    state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {slot_r, cur_head};
    unique case (state_r)
      ST_LOOKUP: ram_addr = {lk.hit_idx, head_r[lk.hit_idx]};
      ST_EVAL: begin
        if (fits) begin
          ram_we   = 1'b1;
          ram_addr = {slot_r, tail_pos};
        end
      end
      default: ram_addr = {slot_r, cur_head};
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 24'd65536;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      mode_r   <= in_tdata[1:0];
      dest_r   <= in_tdata[33:2];
      port_r   <= in_tdata[49:34];
      orig_r   <= in_tdata[81:50];
      len_r    <= in_tdata[97:82];
      handle_r <= in_tdata[129:98];
    end
  end

  // Slot tags are written only when a slot is claimed.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP && mode_r == MODE_STORE && !lk.hit && lk.free_ok) begin
      tag_r[lk.free_idx] <= dest_r;
    end
  end

  // Queue state, accounting and result fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      bytes_r     <= '0;
      pkts_r      <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < DEST_SLOTS; s++) begin
        head_r[s]  <= '0;
        count_r[s] <= '0;
      end
    end else begin
      // The output register is loaded when a result is done and cleared when taken.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          stat_r  <= STAT_DONE;
          evict_r <= '0;
          desc_r  <= '0;
        end
        ST_LOOKUP: begin
          if (lk.hit) begin
            slot_r    <= lk.hit_idx;
            slot_ok_r <= 1'b1;
          end else if (mode_r == MODE_STORE && lk.free_ok) begin
            slot_r                <= lk.free_idx;
            slot_ok_r             <= 1'b1;
            used_r[lk.free_idx]   <= 1'b1;
            head_r[lk.free_idx]   <= '0;
            count_r[lk.free_idx]  <= '0;
          end else begin
            slot_r    <= '0;
            slot_ok_r <= 1'b0;
          end
          if (mode_r == MODE_STORE) begin
            if (!lk.hit && !lk.free_ok) stat_r <= STAT_NO_SLOT;
          end else if (!lk.hit || count_r[lk.hit_idx] == '0) begin
            stat_r <= STAT_EMPTY;
          end
        end
        ST_EVAL: begin
          if (fits) begin
            count_r[slot_r] <= cur_cnt + 1'b1;
            bytes_r         <= bytes_r + 24'(len_r);
            pkts_r          <= pkts_r + 1'b1;
          end else if (cur_cnt == '0) begin
            stat_r <= STAT_NO_ROOM;
          end
        end
        ST_EVICT: begin
          head_r[slot_r]  <= cur_head + 1'b1;
          count_r[slot_r] <= cur_cnt - 1'b1;
          bytes_r         <= bytes_r - 24'(ram_rdata[15:0]);
          pkts_r          <= pkts_r - 1'b1;
          evict_r         <= evict_r + 1'b1;
        end
        ST_GET: begin
          head_r[slot_r]  <= cur_head + 1'b1;
          count_r[slot_r] <= cur_cnt - 1'b1;
          bytes_r         <= bytes_r - 24'(ram_rdata[15:0]);
          pkts_r          <= pkts_r - 1'b1;
          desc_r          <= ram_rdata;
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r[1:0]     <= stat_r;
      out_data_r[6:2]     <= evict_r;
      out_data_r[22:7]    <= desc_r[31:16];
      out_data_r[54:23]   <= desc_r[63:32];
      out_data_r[70:55]   <= desc_r[15:0];
      out_data_r[102:71]  <= desc_r[95:64];
      out_data_r[103]     <= more;
      out_data_r[127:104] <= avail;
      out_data_r[137:128] <= pkts_r;
      out_data_r[143:138] <= '0;
    end
  end

endmodule
`default_nettype wire

### dv/per_destination_packet_queue_tb.sv
// ----------------------------------------------------------------------------
// Per-destination packet queue testbench
// Drives store, get and probe transfers under several byte budgets, predicts
// every result with an independent model of the queues and compares each
// result field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module per_destination_packet_queue_tb
  import pdq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_PROBE = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int POOL_SIZE  = 24;
  localparam int IDLE_LIMIT = 5000;

  // Result fields from the highest bit down, matching the output packing.
  typedef struct packed {
    logic [9:0]   total;
    logic [23:0]  avail;
    logic         more;
    logic [31:0]  handle;
    logic [15:0]  length;
    logic [31:0]  origin;
    logic [15:0]  port;
    logic [4:0]   evicted;
    status_t      status;
  } queue_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [23:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  // mode, destination, port_id, origin, length, payload_handle, zero pad
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // status, evicted_count, out_port, out_origin, out_length, out_handle,
  // more_waiting, available_bytes, total_packets, zero pad
  logic [143:0] out_tdata;

  per_destination_packet_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the queue state.
  logic [23:0] budget;
  logic [31:0] tag_of [DEST_SLOTS];
  logic        claimed [DEST_SLOTS];
  int          head_of [DEST_SLOTS];
  int          depth_of [DEST_SLOTS];
  logic [15:0] desc_len [ENTRIES];
  logic [15:0] desc_port [ENTRIES];
  logic [31:0] desc_origin [ENTRIES];
  logic [31:0] desc_handle [ENTRIES];
  int          bytes_held;
  int          packets_total;

  queue_result_t pending_results[$];
  logic [31:0]   dest_pool [POOL_SIZE];
  int            error_count;
  int            idle_cycles;
  int            len_ceiling;
  logic          no_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predict one result and advance the shadow state.
  function automatic queue_result_t predict_queue_op(logic [1:0] mode, logic [31:0] dest,
      logic [15:0] port, logic [31:0] origin, logic [15:0] len, logic [31:0] handle);
    queue_result_t r;
    int s;
    int e;
    r = '0;
    r.status = STAT_DONE;
    s = -1;
    for (int i = DEST_SLOTS - 1; i >= 0; i--) begin
      if (claimed[i] && tag_of[i] == dest) s = i;
    end
    if (mode == MODE_STORE) begin
      if (s < 0) begin
        for (int i = DEST_SLOTS - 1; i >= 0; i--) begin
          if (!claimed[i]) s = i;
        end
        if (s >= 0) begin
          claimed[s] = 1'b1;
          tag_of[s] = dest;
          head_of[s] = 0;
          depth_of[s] = 0;
        end
      end
      if (s < 0) begin
        r.status = STAT_NO_SLOT;
      end else begin
        // Drop the oldest packets until the new one fits in bytes and depth.
        forever begin
          if (bytes_held + int'(len) <= int'(budget) && depth_of[s] < QUEUE_DEPTH) begin
            e = s * QUEUE_DEPTH + (head_of[s] + depth_of[s]) % QUEUE_DEPTH;
            desc_len[e] = len;
            desc_port[e] = port;
            desc_origin[e] = origin;
            desc_handle[e] = handle;
            depth_of[s]++;
            bytes_held += len;
            packets_total++;
            break;
          end
          if (depth_of[s] > 0) begin
            e = s * QUEUE_DEPTH + head_of[s];
            head_of[s] = (head_of[s] + 1) % QUEUE_DEPTH;
            depth_of[s]--;
            bytes_held -= desc_len[e];
            packets_total--;
            r.evicted = r.evicted + 5'd1;
          end else begin
            r.status = STAT_NO_ROOM;
            break;
          end
        end
        r.more = depth_of[s] > 0;
      end
    end else if (mode == MODE_GET) begin
      if (s < 0 || depth_of[s] == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        e = s * QUEUE_DEPTH + head_of[s];
        head_of[s] = (head_of[s] + 1) % QUEUE_DEPTH;
        depth_of[s]--;
        bytes_held -= desc_len[e];
        packets_total--;
        r.port = desc_port[e];
        r.origin = desc_origin[e];
        r.length = desc_len[e];
        r.handle = desc_handle[e];
        r.more = depth_of[s] > 0;
      end
    end else begin
      if (s >= 0 && depth_of[s] > 0) r.more = 1'b1;
      else r.status = STAT_EMPTY;
    end
    r.avail = (int'(budget) > bytes_held) ? 24'(int'(budget) - bytes_held) : 24'd0;
    r.total = 10'(packets_total);
    return r;
  endfunction

  // Send one item; it is predicted at the edge where its transfer happens.
  task automatic send_item(logic [1:0] mode, logic [31:0] dest, logic [15:0] port,
      logic [31:0] origin, logic [15:0] len, logic [31:0] handle);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, handle, len, origin, port, dest, mode};
    do @(posedge clk); while (!in_tready);
    pending_results = {pending_results,
                       predict_queue_op(mode, dest, port, origin, len, handle)};
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the block drain before touching the budget register.
  task automatic write_budget(logic [23:0] value);
    @(posedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    budget = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[137:0];
      if (pending_results.size() == 0) begin
        $display("result transfer with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.evicted != want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
        if (got.port != want.port) report_mismatch("port", got.port, want.port);
        if (got.origin != want.origin) report_mismatch("origin", got.origin, want.origin);
        if (got.length != want.length) report_mismatch("length", got.length, want.length);
        if (got.handle != want.handle) report_mismatch("handle", got.handle, want.handle);
        if (got.more != want.more) report_mismatch("more", got.more, want.more);
        if (got.avail != want.avail) report_mismatch("avail", got.avail, want.avail);
        if (got.total != want.total) report_mismatch("total", got.total, want.total);
      end
    end
  end

  // Receiver back-pressure: runs of ready, short and occasional long stalls.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk);
      if (!no_stall) begin
        out_tready <= 1'b0;
        repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("per_destination_packet_queue_tb: done, errors");
      $finish;
    end
  end

  task automatic test_basic_ops();
    send_item(MODE_PROBE, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_STORE, dest_pool[0], 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
    send_item(MODE_STORE, dest_pool[0], 16'h0000, 32'h0000_0000, 16'd1234, 32'h0);
    send_item(MODE_STORE, dest_pool[1], 16'hA5A5, 32'h5A5A_5A5A, 16'd100, 32'hDEAD_BEEF);
    send_item(MODE_PROBE, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_SPARE, dest_pool[1], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_PROBE, 32'h7777_0001, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, 32'h7777_0001, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(MODE_GET, dest_pool[1], 16'd0, 32'd0, 16'd0, 32'd0);
  endtask

  // Seventeen stores into one queue force a depth eviction.
  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      send_item(MODE_STORE, dest_pool[2], 16'(i), 32'(i), 16'd10, 32'(i * 3));
    end
  endtask

  // Under a small budget a full-length packet empties the queue and is dropped.
  task automatic test_oversize();
    write_budget(24'd1000);
    send_item(MODE_STORE, dest_pool[3], 16'd1, 32'd1, 16'd400, 32'd1);
    send_item(MODE_STORE, dest_pool[3], 16'd2, 32'd2, 16'd400, 32'd2);
    send_item(MODE_STORE, dest_pool[3], 16'd3, 32'd3, 16'd400, 32'd3);
    send_item(MODE_STORE, dest_pool[3], 16'd4, 32'd4, 16'hFFFF, 32'd4);
    send_item(MODE_STORE, dest_pool[2], 16'd5, 32'd5, 16'd1000, 32'd5);
  endtask

  task automatic test_random(int count);
    logic [1:0]  mode;
    logic [31:0] dest;
    logic [15:0] len;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      mode = (pick < 50) ? MODE_STORE : (pick < 80) ? MODE_GET :
             (pick < 95) ? MODE_PROBE : MODE_SPARE;
      dest = ($urandom_range(0, 19) == 0) ? $urandom
                                          : dest_pool[$urandom_range(0, POOL_SIZE - 1)];
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, len_ceiling));
      if (n == count / 2) no_stall = 1'b1;
      if (n == count * 3 / 4) no_stall = 1'b0;
      send_item(mode, dest, 16'($urandom), $urandom, len, $urandom);
    end
  endtask

  // Claim every remaining slot, then one more unknown destination.
  task automatic test_slot_exhaustion();
    for (int i = 0; i < DEST_SLOTS + 1; i++) begin
      send_item(MODE_STORE, 32'hC0A8_0000 + 32'(i), 16'd7, 32'd7, 16'd1, 32'd7);
    end
    send_item(MODE_GET, 32'hC0A8_0000 + 32'(DEST_SLOTS), 16'd0, 32'd0, 16'd0, 32'd0);
  endtask

  // Lowering the budget under what is held keeps contents and forces evictions.
  task automatic test_budget_lowered();
    write_budget(24'd50);
    send_item(MODE_PROBE, dest_pool[0], 16'd0, 32'd0, 16'd0, 32'd0);
    len_ceiling = 40;
    test_random(100);
  endtask

  initial begin
    error_count = 0;
    no_stall = 1'b0;
    len_ceiling = 200;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    budget = 24'd65536;
    bytes_held = 0;
    packets_total = 0;
    for (int i = 0; i < DEST_SLOTS; i++) begin
      claimed[i] = 1'b0;
      head_of[i] = 0;
      depth_of[i] = 0;
      tag_of[i] = '0;
    end
    dest_pool[0] = 32'h0000_0000;
    dest_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) dest_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_full_queue();
    test_oversize();
    write_budget(24'd65536);
    test_random(400);
    write_budget(24'd1200);
    test_random(450);
    write_budget(24'hFF_FFFF);
    len_ceiling = 65535;
    test_random(300);
    write_budget(24'd1);
    len_ceiling = 2;
    test_random(100);
    write_budget(24'($urandom_range(1, 24'hFF_FFFF)));
    len_ceiling = 2000;
    test_random(150);
    write_budget(24'd65536);
    test_slot_exhaustion();
    len_ceiling = 300;
    test_random(100);
    test_budget_lowered();

    @(posedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("per_destination_packet_queue_tb: done, clean");
    end else begin
      $display("per_destination_packet_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
